// File: src/fwl_pkg.sv
// Shared types and constants for the flash wear-leveling map.
// Holds the request and command codes, the item layouts, and the
// control and status records between the sequencer and the datapath.
package fwl_pkg;

    localparam int LOGICAL_BLOCKS = 32;
    localparam int LB_W = 5;
    localparam int OP_W = 2;
    localparam int THR_W = 16;
    localparam logic [THR_W-1:0] THR_RESET = 16'd5;
    localparam int BLK_FIELD_W = 5;
    localparam int CMD_W = 3;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_PAD_W = OUT_TDATA_W - CMD_W - 2 * BLK_FIELD_W;

    typedef enum logic [OP_W-1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_ERASE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ     = 3'd0,
        CMD_PROGRAM  = 3'd1,
        CMD_ERASE    = 3'd2,
        CMD_COPY     = 3'd3,
        CMD_UNMAPPED = 3'd4
    } cmd_code_t;

    typedef enum logic [2:0] {
        EM_READ,
        EM_UNMAP,
        EM_ERASE_OLD,
        EM_COPY,
        EM_ERASE_COLD,
        EM_PROGRAM
    } emit_t;

    typedef struct packed {
        logic  clr_step;
        logic  take;
        logic  scan_start;
        logic  scan_run;
        logic  want_free;
        logic  save_tgt;
        logic  wr_old;
        logic  clr_map_lb;
        logic  claim_tgt;
        logic  remap_start;
        logic  remap_step;
        logic  erase_cold;
        logic  finalize;
        logic  emit;
        emit_t emit_kind;
        logic  emit_last;
    } fwl_cmd_t;

    typedef struct packed {
        logic clr_last;
        op_t  op;
        logic map_hit;
        logic scan_done;
        logic found;
        logic ge_thr;
        logic remap_last;
        logic out_free;
    } fwl_stat_t;

endpackage

// File: src/fwl_ctrl.sv
// Sequencer for the flash wear-leveling map.
// Steps each request through lookup, counter scans, remap and command
// output; depends on fwl_pkg and drives fwl_dp through fwl_cmd_t.
module fwl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fwl_pkg::fwl_stat_t stat,
    output fwl_pkg::fwl_cmd_t  cmd
);
    import fwl_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_OLD,
        S_SCAN_F,
        S_NOFREE,
        S_SCAN_C,
        S_COPY,
        S_REMAP,
        S_ECOLD,
        S_PROG
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd = '0;
        cmd.emit_kind = EM_UNMAP;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.op)
                    OP_READ:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit = 1'b1;
                            cmd.emit_kind = stat.map_hit ? EM_READ : EM_UNMAP;
                            cmd.emit_last = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    OP_ERASE:
                    begin
                        if (stat.map_hit)
                        begin
                            state_next = S_OLD;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.emit = 1'b1;
                            cmd.emit_kind = EM_UNMAP;
                            cmd.emit_last = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    OP_WRITE:
                    begin
                        if (stat.map_hit)
                        begin
                            state_next = S_OLD;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next = S_SCAN_F;
                        end
                    end
                    OP_NONE:
                    begin
                        state_next = S_IDLE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_OLD:
            begin
                if (stat.out_free)
                begin
                    cmd.wr_old = 1'b1;
                    cmd.clr_map_lb = 1'b1;
                    cmd.emit = 1'b1;
                    cmd.emit_kind = EM_ERASE_OLD;
                    cmd.emit_last = (stat.op == OP_ERASE);
                    if (stat.op == OP_ERASE)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next = S_SCAN_F;
                    end
                end
            end
            S_SCAN_F:
            begin
                cmd.scan_run = 1'b1;
                cmd.want_free = 1'b1;
                if (stat.scan_done)
                begin
                    if (!stat.found)
                    begin
                        state_next = S_NOFREE;
                    end
                    else if (stat.ge_thr)
                    begin
                        cmd.save_tgt = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_next = S_SCAN_C;
                    end
                    else
                    begin
                        cmd.save_tgt = 1'b1;
                        state_next = S_PROG;
                    end
                end
            end
            S_NOFREE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_kind = EM_UNMAP;
                    cmd.emit_last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN_C:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = stat.found ? S_COPY : S_PROG;
                end
            end
            S_COPY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_kind = EM_COPY;
                    cmd.claim_tgt = 1'b1;
                    cmd.remap_start = 1'b1;
                    state_next = S_REMAP;
                end
            end
            S_REMAP:
            begin
                cmd.remap_step = 1'b1;
                if (stat.remap_last)
                begin
                    state_next = S_ECOLD;
                end
            end
            S_ECOLD:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_kind = EM_ERASE_COLD;
                    cmd.erase_cold = 1'b1;
                    state_next = S_PROG;
                end
            end
            S_PROG:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_kind = EM_PROGRAM;
                    cmd.emit_last = 1'b1;
                    cmd.finalize = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/fwl_dp.sv
// Datapath for the flash wear-leveling map: erase counter memory with
// free flags, logical map, scan unit, threshold register and output register.
// Depends on fwl_pkg; controlled by fwl_ctrl through fwl_cmd_t.
module fwl_dp #(
    parameter int NUM_BLOCKS  = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [fwl_pkg::IN_TDATA_W-1:0]   in_data,
    input  logic                             cfg_valid,
    input  logic [fwl_pkg::THR_W-1:0]        cfg_data,
    input  fwl_pkg::fwl_cmd_t                cmd,
    output fwl_pkg::fwl_stat_t               stat,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [fwl_pkg::OUT_TDATA_W-1:0]  out_data,
    output logic                             out_last
);
    import fwl_pkg::*;

    localparam int BW = $clog2(NUM_BLOCKS);
    localparam int SW = $clog2(NUM_BLOCKS + 1);
    localparam int MW = COUNT_WIDTH + 1;
    localparam int CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    logic [MW-1:0]          cnt_mem [NUM_BLOCKS];
    logic [MW-1:0]          rd_data_reg;
    logic [BW-1:0]          rd_addr;
    logic                   wr_en;
    logic [BW-1:0]          wr_addr;
    logic [MW-1:0]          wr_data;
    logic                   rd_free;
    logic [COUNT_WIDTH-1:0] rd_cnt;

    op_t                    op_reg;
    logic [LB_W-1:0]        lb_reg;
    logic [THR_W-1:0]       thr_reg;
    logic [BW-1:0]          clr_idx_reg;

    logic                   map_valid_reg [LOGICAL_BLOCKS];
    logic [BW-1:0]          map_phys_reg [LOGICAL_BLOCKS];
    logic [LB_W-1:0]        remap_idx_reg;
    logic [LB_W-1:0]        map_addr;
    logic                   map_hit;
    logic [BW-1:0]          map_phys;
    logic                   remap_hit;

    logic [SW-1:0]          scan_idx_reg;
    logic                   scan_issued;
    logic                   pipe_vld_reg;
    logic [BW-1:0]          pipe_idx_reg;
    logic                   found_reg;
    logic [BW-1:0]          best_idx_reg;
    logic [COUNT_WIDTH-1:0] best_cnt_reg;
    logic                   better;

    logic [BW-1:0]          tgt_idx_reg;
    logic [COUNT_WIDTH-1:0] tgt_cnt_reg;

    logic                   out_valid_reg;
    cmd_code_t              out_cmd_reg;
    logic [BLK_FIELD_W-1:0] out_phys_reg;
    logic [BLK_FIELD_W-1:0] out_src_reg;
    logic                   out_last_reg;
    cmd_code_t              e_cmd;
    logic [BW-1:0]          e_phys;
    logic [BW-1:0]          e_src;

    assign rd_free = rd_data_reg[COUNT_WIDTH];
    assign rd_cnt  = rd_data_reg[COUNT_WIDTH-1:0];

    assign map_addr  = cmd.remap_step ? remap_idx_reg : lb_reg;
    assign map_hit   = map_valid_reg[map_addr];
    assign map_phys  = map_phys_reg[map_addr];
    assign remap_hit = map_hit && (map_phys == best_idx_reg);

    assign scan_issued = (scan_idx_reg == SW'(NUM_BLOCKS));
    assign better = pipe_vld_reg && (rd_free == cmd.want_free)
                    && (!found_reg || (rd_cnt < best_cnt_reg));

    assign rd_addr = cmd.scan_run ? scan_idx_reg[BW-1:0] : map_phys;

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = tgt_idx_reg;
        wr_data = {1'b0, tgt_cnt_reg};
        priority if (cmd.clr_step)
        begin
            wr_en = 1'b1;
            wr_addr = clr_idx_reg;
            wr_data = {1'b1, {COUNT_WIDTH{1'b0}}};
        end
        else if (cmd.wr_old)
        begin
            wr_en = 1'b1;
            wr_addr = map_phys;
            wr_data = {1'b1, sat_inc(rd_cnt)};
        end
        else if (cmd.erase_cold)
        begin
            wr_en = 1'b1;
            wr_addr = best_idx_reg;
            wr_data = {1'b1, sat_inc(best_cnt_reg)};
        end
        else if (cmd.claim_tgt || cmd.finalize)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cnt_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= cnt_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            clr_idx_reg <= '0;
            scan_idx_reg <= '0;
            pipe_vld_reg <= 1'b0;
            found_reg <= 1'b0;
            remap_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
            if (cmd.clr_step)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.scan_start)
            begin
                scan_idx_reg <= '0;
                pipe_vld_reg <= 1'b0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                pipe_vld_reg <= !scan_issued;
                if (!scan_issued)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (better)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.remap_start)
            begin
                remap_idx_reg <= '0;
            end
            else if (cmd.remap_step && !remap_hit)
            begin
                remap_idx_reg <= remap_idx_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LOGICAL_BLOCKS; i++)
            begin
                map_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.clr_map_lb)
            begin
                map_valid_reg[lb_reg] <= 1'b0;
            end
            if (cmd.finalize)
            begin
                map_valid_reg[lb_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg <= op_t'(in_data[OP_W-1:0]);
            lb_reg <= in_data[OP_W+LB_W-1:OP_W];
        end
        if (cmd.finalize)
        begin
            map_phys_reg[lb_reg] <= tgt_idx_reg;
        end
        else if (cmd.remap_step && remap_hit)
        begin
            map_phys_reg[remap_idx_reg] <= tgt_idx_reg;
        end
        if (cmd.scan_run)
        begin
            pipe_idx_reg <= scan_idx_reg[BW-1:0];
            if (better)
            begin
                best_idx_reg <= pipe_idx_reg;
                best_cnt_reg <= rd_cnt;
            end
        end
        if (cmd.save_tgt)
        begin
            tgt_idx_reg <= best_idx_reg;
            tgt_cnt_reg <= best_cnt_reg;
        end
        else if (cmd.erase_cold)
        begin
            tgt_idx_reg <= best_idx_reg;
            tgt_cnt_reg <= sat_inc(best_cnt_reg);
        end
        if (cmd.emit)
        begin
            out_cmd_reg <= e_cmd;
            out_phys_reg <= BLK_FIELD_W'(e_phys);
            out_src_reg <= BLK_FIELD_W'(e_src);
            out_last_reg <= cmd.emit_last;
        end
    end

    always_comb
    begin
        e_cmd = CMD_UNMAPPED;
        e_phys = '0;
        e_src = '0;
        unique case (cmd.emit_kind)
            EM_READ:
            begin
                e_cmd = CMD_READ;
                e_phys = map_phys;
            end
            EM_UNMAP:
            begin
                e_cmd = CMD_UNMAPPED;
            end
            EM_ERASE_OLD:
            begin
                e_cmd = CMD_ERASE;
                e_phys = map_phys;
            end
            EM_COPY:
            begin
                e_cmd = CMD_COPY;
                e_phys = tgt_idx_reg;
                e_src = best_idx_reg;
            end
            EM_ERASE_COLD:
            begin
                e_cmd = CMD_ERASE;
                e_phys = best_idx_reg;
            end
            EM_PROGRAM:
            begin
                e_cmd = CMD_PROGRAM;
                e_phys = tgt_idx_reg;
            end
            default:
            begin
                e_cmd = CMD_UNMAPPED;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{OUT_PAD_W{1'b0}}, out_src_reg, out_phys_reg, out_cmd_reg};
    assign out_last  = out_last_reg;

    assign stat.clr_last   = (clr_idx_reg == BW'(NUM_BLOCKS - 1));
    assign stat.op         = op_reg;
    assign stat.map_hit    = map_hit;
    assign stat.scan_done  = scan_issued && !pipe_vld_reg;
    assign stat.found      = found_reg;
    assign stat.ge_thr     = (CMP_W'(best_cnt_reg) >= CMP_W'(thr_reg));
    assign stat.remap_last = remap_hit || (remap_idx_reg == LB_W'(LOGICAL_BLOCKS - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

// File: src/flash_wear_leveling_map.sv
// Top level of the flash wear-leveling map.
// Joins the sequencer fwl_ctrl and the datapath fwl_dp; uses fwl_pkg.
//
// Channel   Direction  Handshake                     Content
// s_axis    in         s_axis_tvalid/s_axis_tready   one request item
// m_axis    out        m_axis_tvalid/m_axis_tready   one flash command item
// cfg       in         cfg_valid/cfg_ready           wear threshold value
//
// After reset a clearing pass sets every counter entry to free with a zero count.
// A write makes up to two passes over the counter memory read port and one pass
// over the logical map.
// A stalled output holds its item; the next request is taken once the last
// command of the current one is in the output register.
module flash_wear_leveling_map #(
    parameter int NUM_BLOCKS  = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: op [1:0], logical_block [6:2], zero [7].
    input  logic [fwl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: command [2:0], phys_block [7:3], source_block [12:8], zero.
    output logic [fwl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fwl_pkg::THR_W-1:0]       cfg_data
);
    import fwl_pkg::*;

    fwl_cmd_t  cmd;
    fwl_stat_t stat;

    assign cfg_ready = 1'b1;

    fwl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fwl_dp #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// File: src/fwl_chk.sv
// Port-level checks for the flash wear-leveling map, bound to the top level.
// Depends on fwl_pkg for the command codes and item widths.
module fwl_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [fwl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);
    import fwl_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one in progress");

    a_src_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] != CMD_COPY) |-> m_axis_tdata[12:8] == 5'd0)
        else $error("source block set on a non-copy command");

    a_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] == CMD_UNMAPPED) |->
        m_axis_tlast && (m_axis_tdata[7:3] == 5'd0))
        else $error("unmapped code without last or with a block number");

    a_cmd_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
        ((m_axis_tdata[2:0] == CMD_PROGRAM) && m_axis_tlast) ||
        ((m_axis_tdata[2:0] == CMD_READ) && m_axis_tlast) ||
        ((m_axis_tdata[2:0] == CMD_COPY) && !m_axis_tlast) ||
        (m_axis_tdata[2:0] == CMD_ERASE) ||
        (m_axis_tdata[2:0] == CMD_UNMAPPED))
        else $error("bad command code or end-of-request marking");

endmodule

bind flash_wear_leveling_map fwl_chk u_fwl_chk (.*);
